@@ rtl/bmf_pkg.sv @@
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants and types for the block median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

	localparam int WINDOW   = 8;
	localparam int SAMPLE_W = 10;
	localparam int CNT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W    = SAMPLE_W + 1;

	// Middle positions of the sorted block; equal for an odd window.
	localparam int MID_LO = (WINDOW - 1) / 2;
	localparam int MID_HI = WINDOW / 2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]    count_t;

	// Link from one sort cell to the next one up the chain.
	typedef struct packed {
		logic    take;
		sample_t value;
	} bmf_link_t;

endpackage

`default_nettype wire

@@ rtl/block_median_filter.sv @@
// ----------------------------------------------------------------------------
// block_median_filter
// Median of each block of WINDOW samples, sorted on the fly in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   Drive sample and pulse start; a transfer happens at every clock edge with
//   start high and busy low. busy stays low, so one sample per cycle is taken.
//   Each sample is inserted in sorted order into a row of WINDOW cells in the
//   cycle it arrives; a fill counter marks which cells belong to the block.
//   The sample that completes a block makes one result: strobe is high for
//   one cycle with median, registered in done_s1 and then strobe_q after
//   that sample's transfer. Other samples give no result. The next block
//   may start in the very next cycle; the median register samples the full
//   chain at the same edge that the new block's first sample overwrites cell
//   zero.
//   Throughput: 1 sample per cycle, set by the broadcast insert.
//   Reset clears the fill counter and the result strobe; cell contents stay
//   undefined until written. The receiver cannot stall: a result is present
//   for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_median_filter (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bmf_pkg::sample_t sample,
	output logic                  strobe,
	output bmf_pkg::sample_t      median
);
	import bmf_pkg::*;

	logic       accept;
	logic       last;
	count_t     count_q;
	logic       done_s1;
	logic       strobe_q;
	sample_t    median_q;
	logic [SUM_W-1:0] mid_sum;

	bmf_link_t  link [WINDOW+1];
	sample_t    cell_value [WINDOW];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign last   = (count_q == count_t'(WINDOW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept && last;
			if (accept) begin
				count_q <= last ? '0 : count_q + count_t'(1);
			end
		end
	end

	// Cell zero sees no lower neighbor.
	assign link[0] = '{take: 1'b0, value: '0};

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		bmf_cell u_cell (
			.clk      (clk),
			.shift_en (accept),
			.sample   (sample),
			.occupied (count_q > count_t'(i)),
			.left     (link[i]),
			.right    (link[i+1]),
			.value    (cell_value[i])
		);
	end

	assign mid_sum = {1'b0, cell_value[MID_LO]} + {1'b0, cell_value[MID_HI]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= done_s1;
		end
	end

	// Halve with truncation; an odd window adds the middle value to itself.
	always_ff @(posedge clk) begin
		if (done_s1) begin
			median_q <= mid_sum[SUM_W-1:1];
		end
	end

	assign strobe = strobe_q;
	assign median = median_q;

endmodule

`default_nettype wire

@@ rtl/bmf_cell.sv @@
// ----------------------------------------------------------------------------
// bmf_cell
// One insertion-sort cell: holds one sample and shifts it up when a new
// sample lands at or below its position.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_cell (
	input  wire logic               clk,
	input  wire logic               shift_en,
	input  wire bmf_pkg::sample_t   sample,
	input  wire logic               occupied,
	input  wire bmf_pkg::bmf_link_t left,
	output bmf_pkg::bmf_link_t      right,
	output bmf_pkg::sample_t        value
);
	import bmf_pkg::*;

	sample_t value_q;
	logic    take;

	// An empty cell acts as plus infinity.
	assign take = !occupied || (sample < value_q);

	always_ff @(posedge clk) begin
		if (shift_en && take) begin
			value_q <= left.take ? left.value : sample;
		end
	end

	assign right.take  = take;
	assign right.value = value_q;
	assign value       = value_q;

endmodule

`default_nettype wire

@@ rtl/bmf_checker.sv @@
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks on the block median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire bmf_pkg::sample_t sample,
	input wire logic             strobe,
	input wire bmf_pkg::sample_t median
);
	import bmf_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_strobe_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, 2))
		else $error("result without a sample transfer two cycles earlier");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (WINDOW > 1) |=> !strobe)
		else $error("results in adjacent cycles with a multi-sample window");

	a_single_window: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (WINDOW == 1) |-> median == $past(sample, 2))
		else $error("single-sample window did not pass the sample through");

endmodule

bind block_median_filter bmf_checker u_bmf_checker (.*);

`default_nettype wire
